### hw/rtl/tcp_connection_tracker_top_assert.svh
// Assertion macros shared by the connection tracker RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef TCP_CONNECTION_TRACKER_TOP_ASSERT_SVH
`define TCP_CONNECTION_TRACKER_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

### hw/rtl/tct_pkg.sv
// Types and constants of the TCP connection tracker.
// No dependencies.
package tct_pkg;
    localparam logic [7:0] FL_FIN = 8'h01;
    localparam logic [7:0] FL_SYN = 8'h02;
    localparam logic [7:0] FL_RST = 8'h04;
    localparam logic [7:0] FL_ACK = 8'h10;
    localparam logic [31:0] LCG_MUL = 32'd1664525;
    localparam logic [31:0] LCG_ADD = 32'd1013904223;
    localparam logic [31:0] SEED_RESET = 32'd12345678;
    localparam logic [15:0] LISTEN_RESET = 16'd80;
    localparam logic [15:0] HDR_MIN_BYTES = 16'd20;

    localparam logic [2:0] ACT_DROP = 3'd0;
    localparam logic [2:0] ACT_SYN = 3'd1;
    localparam logic [2:0] ACT_FIN = 3'd2;
    localparam logic [2:0] ACT_RST = 3'd3;
    localparam logic [2:0] ACT_HS = 3'd4;
    localparam logic [2:0] ACT_DATA = 3'd5;
    localparam logic [2:0] ACT_IGN = 3'd6;

    typedef struct packed {
        logic [31:0] peer_ip;
        logic [15:0] peer_port;
        logic [15:0] target_port;
        logic [31:0] seq_in;
        logic [31:0] ack_in;
        logic [7:0]  flag_bits;
        logic [3:0]  data_offset;
        logic [15:0] segment_length;
    } seg_t;

    typedef struct packed {
        logic [2:0]  action;
        logic        send_reply;
        logic [7:0]  reply_flags;
        logic [31:0] reply_seq;
        logic [31:0] reply_ack;
        logic [15:0] reply_port;
        logic [31:0] reply_ip;
        logic [2:0]  slot_index;
        logic        deliver;
        logic [15:0] payload_length;
    } res_t;

    // controller -> datapath commands
    typedef struct packed {
        logic load;     // capture the input segment
        logic scan;     // examine one slot
        logic seed;     // register the seed product
        logic commit;   // apply the decision, build the result
    } cmd_t;

    // datapath -> controller status
    typedef struct packed {
        logic scan_last;
    } sts_t;
endpackage

### hw/rtl/tct_datapath.sv
// Datapath: segment registers, slot table, slot scan, seed generator, result.
// Depends on tct_pkg.
module tct_datapath #(
    parameter int MAX_CONNECTIONS = 8
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic [15:0]    listen_port,
    input  tct_pkg::seg_t  seg_in,
    input  tct_pkg::cmd_t  cmd,
    output tct_pkg::sts_t  sts,
    output tct_pkg::res_t  res
);
    import tct_pkg::*;

    localparam int IW = (MAX_CONNECTIONS > 1) ? $clog2(MAX_CONNECTIONS) : 1;
    localparam int CW = $clog2(MAX_CONNECTIONS + 1);

    logic [MAX_CONNECTIONS-1:0] act_reg, hs_reg;
    logic [31:0] sseq_reg  [MAX_CONNECTIONS];
    logic [31:0] sack_reg  [MAX_CONNECTIONS];
    logic [15:0] sport_reg [MAX_CONNECTIONS];
    logic [31:0] sip_reg   [MAX_CONNECTIONS];

    seg_t        seg_reg;
    logic [CW-1:0] idx_reg;
    logic        ipf_reg, mf_reg, ff_reg;    // ip-only hit, match hit, free found
    logic [IW-1:0] mk_reg, fk_reg;
    logic [31:0] seed_reg, prod_reg;
    res_t        res_reg;

    logic [IW-1:0] k;
    assign k = idx_reg[IW-1:0];
    assign sts.scan_last = (idx_reg == CW'(MAX_CONNECTIONS - 1));
    assign res = res_reg;

    logic ip_hit, port_hit;
    assign ip_hit = act_reg[k] && (sip_reg[k] == seg_reg.peer_ip);
    assign port_hit = ip_hit &&
        ((seg_reg.peer_port == 16'd0) || (sport_reg[k] == seg_reg.peer_port));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
            ipf_reg <= 1'b0;
            mf_reg <= 1'b0;
            ff_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            idx_reg <= '0;
            ipf_reg <= 1'b0;
            mf_reg <= 1'b0;
            ff_reg <= 1'b0;
        end
        else if (cmd.scan)
        begin
            if (ip_hit)
                ipf_reg <= 1'b1;
            if (port_hit && !mf_reg)
            begin
                mf_reg <= 1'b1;
                mk_reg <= k;
            end
            if (!act_reg[k] && !ff_reg)
            begin
                ff_reg <= 1'b1;
                fk_reg <= k;
            end
            idx_reg <= idx_reg + CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            seg_reg <= seg_in;
        if (cmd.seed)
            prod_reg <= seed_reg * LCG_MUL;
    end

    // decision
    logic [15:0] hdr_bytes, plen;
    logic        ok;
    logic [31:0] seq1, new_seed, mseq1;
    assign hdr_bytes = {10'd0, seg_reg.data_offset, 2'b00};
    assign plen = seg_reg.segment_length - hdr_bytes;
    assign ok = (seg_reg.segment_length >= HDR_MIN_BYTES) &&
                (seg_reg.target_port == listen_port) &&
                (hdr_bytes <= seg_reg.segment_length);
    assign seq1 = seg_reg.seq_in + 32'd1;
    assign new_seed = prod_reg + LCG_ADD;
    assign mseq1 = sseq_reg[mk_reg] + 32'd1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= '0;
            hs_reg <= '0;
            seed_reg <= SEED_RESET;
        end
        else if (cmd.commit && ok)
        begin
            if ((seg_reg.flag_bits & FL_SYN) != 8'd0)
            begin
                if (!ipf_reg && ff_reg)
                begin
                    seed_reg <= new_seed;
                    act_reg[fk_reg] <= 1'b1;
                    hs_reg[fk_reg] <= 1'b0;
                end
            end
            else if ((seg_reg.flag_bits & (FL_FIN | FL_RST)) != 8'd0)
            begin
                if (mf_reg)
                    act_reg[mk_reg] <= 1'b0;
            end
            else if (mf_reg && !hs_reg[mk_reg] && seg_reg.ack_in == mseq1)
                hs_reg[mk_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg <= '0;
            if (ok)
            begin
                res_reg.payload_length <= plen;
                if ((seg_reg.flag_bits & FL_SYN) != 8'd0)
                begin
                    res_reg.action <= ACT_IGN;
                    if (!ipf_reg && ff_reg)
                    begin
                        sseq_reg[fk_reg] <= new_seed;
                        sack_reg[fk_reg] <= seq1;
                        sport_reg[fk_reg] <= seg_reg.peer_port;
                        sip_reg[fk_reg] <= seg_reg.peer_ip;
                        res_reg.action <= ACT_SYN;
                        res_reg.send_reply <= 1'b1;
                        res_reg.reply_flags <= FL_SYN | FL_ACK;
                        res_reg.reply_seq <= new_seed;
                        res_reg.reply_ack <= seq1;
                        res_reg.reply_port <= seg_reg.peer_port;
                        res_reg.reply_ip <= seg_reg.peer_ip;
                        res_reg.slot_index <= 3'(fk_reg);
                    end
                end
                else if ((seg_reg.flag_bits & FL_FIN) != 8'd0)
                begin
                    res_reg.action <= ACT_FIN;
                    res_reg.send_reply <= 1'b1;
                    res_reg.reply_flags <= FL_FIN | FL_ACK;
                    res_reg.reply_seq <= seg_reg.ack_in;
                    res_reg.reply_ack <= seq1;
                    res_reg.reply_ip <= seg_reg.peer_ip;
                    res_reg.reply_port <= seg_reg.peer_port;
                    if (mf_reg)
                    begin
                        sseq_reg[mk_reg] <= seg_reg.ack_in;
                        sack_reg[mk_reg] <= seq1;
                        res_reg.reply_port <= sport_reg[mk_reg];
                        res_reg.slot_index <= 3'(mk_reg);
                    end
                end
                else if ((seg_reg.flag_bits & FL_RST) != 8'd0)
                begin
                    res_reg.action <= ACT_RST;
                    if (mf_reg)
                        res_reg.slot_index <= 3'(mk_reg);
                end
                else
                begin
                    res_reg.action <= ACT_IGN;
                    if (mf_reg)
                    begin
                        if (!hs_reg[mk_reg] && seg_reg.ack_in == mseq1)
                        begin
                            res_reg.action <= ACT_HS;
                            res_reg.slot_index <= 3'(mk_reg);
                        end
                        else if (plen != 16'd0)
                        begin
                            sseq_reg[mk_reg] <= mseq1;
                            sack_reg[mk_reg] <= sack_reg[mk_reg] + {16'd0, plen};
                            res_reg.action <= ACT_DATA;
                            res_reg.send_reply <= 1'b1;
                            res_reg.reply_flags <= FL_ACK;
                            res_reg.reply_seq <= mseq1;
                            res_reg.reply_ack <= sack_reg[mk_reg] + {16'd0, plen};
                            res_reg.reply_port <= sport_reg[mk_reg];
                            res_reg.reply_ip <= sip_reg[mk_reg];
                            res_reg.slot_index <= 3'(mk_reg);
                            res_reg.deliver <= 1'b1;
                        end
                    end
                end
            end
        end
    end

`include "tcp_connection_tracker_top_assert.svh"
    `ASSERT_IMPL(a_match_implies_ip, clk, rst_n, (cmd.commit && mf_reg) |-> ipf_reg)
    `ASSERT_NEVER(a_scan_past_end, clk, rst_n, cmd.scan && idx_reg >= CW'(MAX_CONNECTIONS))
    `ASSERT_IMPL(a_free_slot_idle, clk, rst_n, (cmd.commit && ff_reg) |-> !act_reg[fk_reg])
endmodule

### hw/rtl/tct_ctrl.sv
// Controller: sequences load, slot scan, seed step, commit and output hold.
// Depends on tct_pkg.
module tct_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    input  tct_pkg::sts_t sts,
    output tct_pkg::cmd_t cmd
);
    import tct_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_SEED = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    logic [1:0] state_reg, state_next;
    logic       ov_reg, ov_next;

    // accept a new item whenever idle and the output slot is free
    assign in_ready = (state_reg == S_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        ov_next = ov_reg;
        if (ov_reg && out_ready)
            ov_next = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    cmd.load = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.scan_last)
                    state_next = S_SEED;
            end
            S_SEED:
            begin
                cmd.seed = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!ov_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

`include "tcp_connection_tracker_top_assert.svh"
    `ASSERT_IMPL(a_load_scans, clk, rst_n, cmd.load |=> (state_reg == S_SCAN))
    `ASSERT_NEVER(a_commit_overwrites, clk, rst_n, cmd.commit && ov_reg && !out_ready)
    `ASSERT_IMPL(a_seed_commit, clk, rst_n, cmd.seed |=> (state_reg == S_DONE))
endmodule

### hw/rtl/tcp_connection_tracker_top.sv
// Top level of the TCP connection tracker: stream ports and APB register.
// Depends on tct_pkg, tct_ctrl, tct_datapath.
//
// Usage:
//   s_axis carries one parsed TCP segment header per transfer; m_axis returns
//   one result per segment: the action taken, the reply header if any and the
//   delivery flag. The APB port holds listen_port at address 0 (reset 80).
// Sequence:
//   An accepted segment is examined one table slot a cycle, then the seed
//   product is registered, then the result is committed once the output
//   register is free. The next segment is taken in the cycle after the
//   commit at the earliest, so segments are processed one at a time.
// Reset:
//   rst_n clears all slots to inactive, sets the sequence seed to 12345678
//   and listen_port to 80. Slot contents are written when a slot opens.
// Stall:
//   A result waits in the output register while m_axis_tready is low; hold
//   s_axis_tready low until that result is taken. The next segment may be
//   taken in the same cycle as the waiting result.
module tcp_connection_tracker_top #(
    parameter int MAX_CONNECTIONS = 8
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // peer_ip, peer_port, target_port, seq_in, ack_in, flag_bits,
    // data_offset, segment_length
    input  logic [159:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // action, send_reply, reply_flags, reply_seq, reply_ack, reply_port,
    // reply_ip, slot_index, deliver, payload_length
    output logic [143:0] m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [1:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    import tct_pkg::*;

    localparam logic [1:0] ADDR_LISTEN = 2'd0;

    logic [15:0] listen_reg;
    seg_t seg;
    res_t res;
    cmd_t cmd;
    sts_t sts;

    // APB: always ready, write on access phase
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LISTEN) ? {16'd0, listen_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            listen_reg <= LISTEN_RESET;
        else if (psel && penable && pwrite && pready && paddr == ADDR_LISTEN)
            listen_reg <= pwdata[15:0];
    end

    // unpack the input transfer, first field lowest
    assign seg.peer_ip = s_axis_tdata[31:0];
    assign seg.peer_port = s_axis_tdata[47:32];
    assign seg.target_port = s_axis_tdata[63:48];
    assign seg.seq_in = s_axis_tdata[95:64];
    assign seg.ack_in = s_axis_tdata[127:96];
    assign seg.flag_bits = s_axis_tdata[135:128];
    assign seg.data_offset = s_axis_tdata[139:136];
    assign seg.segment_length = s_axis_tdata[155:140];

    assign m_axis_tdata = {res.payload_length, res.deliver, res.slot_index,
                           res.reply_ip, res.reply_port, res.reply_ack, res.reply_seq,
                           res.reply_flags, res.send_reply, res.action};

    tct_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .sts       (sts),
        .cmd       (cmd)
    );

    tct_datapath #(
        .MAX_CONNECTIONS (MAX_CONNECTIONS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .listen_port (listen_reg),
        .seg_in      (seg),
        .cmd         (cmd),
        .sts         (sts),
        .res         (res)
    );

`include "tcp_connection_tracker_top_assert.svh"
    `ASSERT_IMPL(a_out_hold, clk, rst_n, (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
    `ASSERT_NEVER(a_no_reply_on_drop, clk, rst_n, m_axis_tvalid && res.action == ACT_DROP && res.send_reply)
    `ASSERT_NEVER(a_deliver_data, clk, rst_n, m_axis_tvalid && res.deliver && res.action != ACT_DATA)
endmodule
